// ===== rtl/multi_channel_timer_table_unit_macros.svh =====
// Assertion macros shared by the timer table RTL.
`ifndef MULTI_CHANNEL_TIMER_TABLE_UNIT_MACROS_SVH
`define MULTI_CHANNEL_TIMER_TABLE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define MCTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MCTT_ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);
`else
`define MCTT_ASSERT(lbl, prop, msg)
`define MCTT_ASSERT_NEVER(lbl, prop, msg)
`endif

`endif

// ===== rtl/mctt_pkg.sv =====
package mctt_pkg;

  localparam int unsigned NumSlotsDef = 8;

  localparam int unsigned OpW      = 3;
  localparam int unsigned IdxW     = 8;
  localparam int unsigned CountW   = 32;
  localparam int unsigned KindW    = 2;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned InDataW  = 48;
  localparam int unsigned OutDataW = 48;

  typedef enum logic [OpW-1:0] {
    OP_TICK   = 3'd0,
    OP_CREATE = 3'd1,
    OP_PAUSE  = 3'd2,
    OP_RESUME = 3'd3,
    OP_RELOAD = 3'd4,
    OP_READ   = 3'd5,
    OP_FREE   = 3'd6
  } op_e;

  typedef enum logic [KindW-1:0] {
    KIND_REPLY  = 2'd0,
    KIND_EXPIRY = 2'd1,
    KIND_END    = 2'd2
  } kind_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_RANGE = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMD,
    ST_READ,
    ST_CREATE,
    ST_TICK,
    ST_END
  } state_e;

endpackage

// ===== rtl/multi_channel_timer_table_unit.sv =====
// Table of NUM_SLOTS software timers driven by a command stream. A tick word
// walks the slots in index order, one slot per clock unless an expiry word
// waits for a full output register, through the single read port of the
// count and reload memories and one shared decrement and compare unit, and
// returns one expiry word per expiring slot followed by an end of tick word.
// A create searches for the first free slot one slot per clock. A read and
// each of the other commands return one reply word. A word that is due
// while the output register is still full holds the command until the
// register is free. The input is accepted only while no command is in
// progress; a finished word may still wait at the output meanwhile.
`include "multi_channel_timer_table_unit_macros.svh"

module multi_channel_timer_table_unit #(
  parameter int unsigned NUM_SLOTS = mctt_pkg::NumSlotsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // timer_index [7:0], timeout [39:8], auto_reload [40], zero fill.
  input  logic [mctt_pkg::InDataW-1:0]  s_axis_tdata_i,
  // op [2:0].
  input  logic [mctt_pkg::OpW-1:0]      s_axis_tuser_i,
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // status [1:0], slot [9:2], remaining [41:10], zero fill.
  output logic [mctt_pkg::OutDataW-1:0] m_axis_tdata_o,
  // kind [1:0].
  output logic [mctt_pkg::KindW-1:0]    m_axis_tuser_o,
  output logic                          m_axis_tlast_o
);

  import mctt_pkg::*;

  localparam int unsigned SlotW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [SlotW-1:0] LastSlot = SlotW'(NUM_SLOTS - 1);
  localparam logic [IdxW-1:0] IdxLimit = IdxW'(NUM_SLOTS);

  state_e state_q, state_d;

  logic [OpW-1:0]    op_q;
  logic [IdxW-1:0]   idx_q;
  logic [CountW-1:0] timeout_q;
  logic              periodic_q;

  logic [NUM_SLOTS-1:0] used_q, used_d;
  logic [NUM_SLOTS-1:0] paused_q, paused_d;
  logic [NUM_SLOTS-1:0] periodic_flags_q, periodic_flags_d;

  logic [SlotW-1:0] scan_q, scan_d;

  logic [CountW-1:0] count_mem [NUM_SLOTS];
  logic [CountW-1:0] reload_mem [NUM_SLOTS];
  logic [CountW-1:0] rd_count_q;
  logic [CountW-1:0] rd_reload_q;
  logic              rd_en;
  logic [SlotW-1:0]  rd_addr;
  logic              cnt_we;
  logic              rld_we;
  logic [SlotW-1:0]  wr_addr;
  logic [CountW-1:0] cnt_wd;

  logic              m_valid_q;
  logic [KindW-1:0]  m_kind_q;
  logic [StatusW-1:0] m_status_q;
  logic [IdxW-1:0]   m_slot_q;
  logic [CountW-1:0] m_rem_q;
  logic              m_last_q;

  logic              out_load;
  kind_e             o_kind;
  status_e           o_status;
  logic [IdxW-1:0]   o_slot;
  logic [CountW-1:0] o_rem;
  logic              o_last;

  logic             s_accept;
  logic             out_free;
  logic             idx_ok;
  logic [SlotW-1:0] idx_slot;
  logic             scan_last;
  logic             tick_active;
  logic             tick_expire;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_accept        = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign idx_ok          = (idx_q < IdxLimit);
  assign idx_slot        = idx_q[SlotW-1:0];
  assign scan_last       = (scan_q == LastSlot);
  assign tick_active     = used_q[scan_q] && !paused_q[scan_q];
  assign tick_expire     = tick_active && (rd_count_q == '0);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_accept) state_d = ST_CMD;
      end
      ST_CMD: begin
        unique case (op_q)
          OP_TICK:   state_d = ST_TICK;
          OP_CREATE: state_d = ST_CREATE;
          OP_READ: begin
            if (idx_ok) begin
              state_d = ST_READ;
            end else if (out_free) begin
              state_d = ST_IDLE;
            end
          end
          default: begin
            if (out_free) state_d = ST_IDLE;
          end
        endcase
      end
      ST_READ: begin
        if (out_free) state_d = ST_IDLE;
      end
      ST_CREATE: begin
        if ((!used_q[scan_q] || scan_last) && out_free) state_d = ST_IDLE;
      end
      ST_TICK: begin
        if (!(tick_expire && !out_free) && scan_last) state_d = ST_END;
      end
      ST_END: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_load         = 1'b0;
    o_kind           = KIND_REPLY;
    o_status         = STATUS_OK;
    o_slot           = '0;
    o_rem            = '0;
    o_last           = 1'b1;
    used_d           = used_q;
    paused_d         = paused_q;
    periodic_flags_d = periodic_flags_q;
    scan_d           = scan_q;
    rd_en            = 1'b0;
    rd_addr          = scan_q;
    cnt_we           = 1'b0;
    rld_we           = 1'b0;
    wr_addr          = idx_slot;
    cnt_wd           = timeout_q;
    unique case (state_q)
      ST_CMD: begin
        unique case (op_q)
          OP_TICK: begin
            scan_d  = '0;
            rd_en   = 1'b1;
            rd_addr = '0;
          end
          OP_CREATE: begin
            scan_d = '0;
          end
          OP_READ: begin
            if (idx_ok) begin
              rd_en   = 1'b1;
              rd_addr = idx_slot;
            end else begin
              out_load = out_free;
              o_status = STATUS_RANGE;
            end
          end
          OP_PAUSE, OP_RESUME, OP_RELOAD, OP_FREE: begin
            out_load = out_free;
            o_status = idx_ok ? STATUS_OK : STATUS_RANGE;
            if (out_free && idx_ok && used_q[idx_slot]) begin
              unique case (op_q)
                OP_PAUSE:  paused_d[idx_slot] = 1'b1;
                OP_RESUME: paused_d[idx_slot] = 1'b0;
                OP_RELOAD: begin
                  cnt_we = 1'b1;
                  rld_we = 1'b1;
                end
                default:   used_d[idx_slot] = 1'b0;
              endcase
            end
          end
          default: begin
            out_load = out_free;
          end
        endcase
      end
      ST_READ: begin
        out_load = out_free;
        o_rem    = used_q[idx_slot] ? rd_count_q : '0;
      end
      ST_CREATE: begin
        wr_addr = scan_q;
        if (!used_q[scan_q]) begin
          out_load = out_free;
          o_slot   = IdxW'(scan_q);
          if (out_free) begin
            used_d[scan_q]           = 1'b1;
            paused_d[scan_q]         = 1'b0;
            periodic_flags_d[scan_q] = periodic_q;
            cnt_we                   = 1'b1;
            rld_we                   = 1'b1;
          end
        end else if (scan_last) begin
          out_load = out_free;
          o_status = STATUS_FULL;
        end else begin
          scan_d = scan_q + SlotW'(1);
        end
      end
      ST_TICK: begin
        wr_addr = scan_q;
        if (tick_expire) begin
          out_load = out_free;
          o_kind   = KIND_EXPIRY;
          o_slot   = IdxW'(scan_q);
          o_last   = 1'b0;
          if (out_free) begin
            if (periodic_flags_q[scan_q]) begin
              cnt_we = 1'b1;
              cnt_wd = rd_reload_q;
            end else begin
              used_d[scan_q] = 1'b0;
            end
          end
        end else if (tick_active) begin
          cnt_we = 1'b1;
          cnt_wd = rd_count_q - CountW'(1);
        end
        if (!(tick_expire && !out_free) && !scan_last) begin
          scan_d  = scan_q + SlotW'(1);
          rd_en   = 1'b1;
          rd_addr = scan_q + SlotW'(1);
        end
      end
      ST_END: begin
        out_load = out_free;
        o_kind   = KIND_END;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      used_q           <= '0;
      paused_q         <= '0;
      periodic_flags_q <= '0;
      scan_q           <= '0;
      m_valid_q        <= 1'b0;
    end else begin
      state_q          <= state_d;
      used_q           <= used_d;
      paused_q         <= paused_d;
      periodic_flags_q <= periodic_flags_d;
      scan_q           <= scan_d;
      if (out_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      op_q       <= s_axis_tuser_i;
      idx_q      <= s_axis_tdata_i[7:0];
      timeout_q  <= s_axis_tdata_i[39:8];
      periodic_q <= s_axis_tdata_i[40];
    end
    if (out_load) begin
      m_kind_q   <= o_kind;
      m_status_q <= o_status;
      m_slot_q   <= o_slot;
      m_rem_q    <= o_rem;
      m_last_q   <= o_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) count_mem[wr_addr] <= cnt_wd;
    if (rld_we) reload_mem[wr_addr] <= timeout_q;
    if (rd_en) begin
      rd_count_q  <= count_mem[rd_addr];
      rd_reload_q <= reload_mem[rd_addr];
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_kind_q;
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tdata_o  = {6'b0, m_rem_q, m_slot_q, m_status_q};

  `MCTT_ASSERT(a_load_only_when_free, out_load |-> out_free, "output word overwritten")
  `MCTT_ASSERT(a_accept_starts_cmd, s_accept |=> (state_q == ST_CMD), "no command after accept")
  `MCTT_ASSERT(a_tick_scan_range, (state_q == ST_TICK) |-> (scan_q <= LastSlot), "tick scan past table")
  `MCTT_ASSERT_NEVER(a_expiry_not_last, m_valid_q && (m_kind_q == KIND_EXPIRY) && m_last_q, "expiry marked last")

endmodule
